FILE: rtl/sclm_pkg.sv
package sclm_pkg;

	localparam int MAX_COMMANDS = 7;
	localparam int NAME_CHARS = 8;
	localparam int MSG_SIZE = 64;
	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int LEN_W = 7;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [2:0] REG_COUNT = 3'd0;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_MATCH = 2'd1,
		PH_PARAM = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_OUT
	} seq_t;

	typedef enum logic [1:0] {
		SCAN_CHAR,
		SCAN_SEP,
		SCAN_END
	} scan_mode_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic param_write;
		logic [5:0] param_pos;
		logic [7:0] param_byte;
		logic ready_res;
		logic [2:0] command_index;
		logic line_dropped;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		logic [63:0] ref_name;
		logic [63:0] test_name;
		logic [POS_W-1:0] pos;
		logic [7:0] ch;
		scan_mode_t mode;
	} cmp_req_t;

	function automatic logic is_sep(input logic [7:0] c);
		return c == CH_COMMA || c == CH_SEMI || c == CH_EQ;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
			|| (c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

FILE: rtl/sclm_cmp.sv
module sclm_cmp (
	input sclm_pkg::cmp_req_t req,
	output logic hit
);
	import sclm_pkg::*;

	logic pre;
	logic [7:0] tb;
	logic [3:0] tlen;

	always_comb begin
		logic done;
		logic [3:0] lim;
		logic [7:0] x;
		logic [7:0] y;
		pre = 1'b1;
		done = 1'b0;
		lim = (req.pos > POS_W'(NAME_CHARS)) ? 4'(NAME_CHARS) : req.pos[3:0];
		tlen = 4'(NAME_CHARS);
		for (int i = NAME_CHARS - 1; i >= 0; i--) begin
			if (req.test_name[8*i +: 8] == 8'h00) tlen = 4'(i);
		end
		for (int i = 0; i < NAME_CHARS; i++) begin
			x = req.ref_name[8*i +: 8];
			y = req.test_name[8*i +: 8];
			if (!done && 4'(i) < lim) begin
				if (x != y) begin
					pre = 1'b0;
					done = 1'b1;
				end else if (x == 8'h00) begin
					done = 1'b1;
				end
			end
		end
		tb = (req.pos < POS_W'(NAME_CHARS)) ? req.test_name[8*req.pos[2:0] +: 8] : 8'h00;
		unique case (req.mode)
			SCAN_CHAR: hit = pre && req.ch == tb;
			default: hit = pre && {2'b00, tlen} == req.pos;
		endcase
	end

endmodule

FILE: rtl/serial_command_line_matcher_unit.sv
// serial command line matcher
// in: valid/stall with in_item_t; a character request or a release request
// out: valid/stall with out_item_t, one result per input request
// cfg: cfg_valid/cfg_ready, cfg_index 0 is the command count, 1..7 the names
// a request that needs no table lookup passes through the scan state to the output state;
// a letter, digit, separator or line end while matching walks the table from
// the current entry with one shared comparer, one entry per cycle, until a hit
// or the end of the table
// the next request is taken in the cycle after the result is accepted; no new
// request is taken while one is in progress
// in_stall is high from the cycle after acceptance until the result is taken
// the result is held in an output register; while out_stall is high it holds
// and no new request is taken
// reset clears all matcher state and the table to zero, nothing is pending
module serial_command_line_matcher_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input sclm_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output sclm_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	import sclm_pkg::*;

	logic [CMD_W-1:0] count_q;
	logic [63:0] names_q [MAX_COMMANDS];
	seq_t seq_q, seq_d;
	phase_t phase_q, phase_d;
	logic cr_q, skip_q, skipne_q, locked_q, scan_q;
	logic cr_d, skip_d, skipne_d, locked_d, scan_d;
	logic [CMD_W-1:0] cand_q, held_q, n_q;
	logic [CMD_W-1:0] cand_d, held_d, n_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0] ch_q, ch_d;
	scan_mode_t mode_q, mode_d;
	out_item_t res_q, res_d;
	cmp_req_t creq;
	logic hit;
	logic [CMD_W-1:0] cnt;

	assign cnt = count_q;
	assign cfg_ready = 1'b1;
	assign in_stall = seq_q != SEQ_IDLE;
	assign out_valid = seq_q == SEQ_OUT;
	assign out_data = res_q;

	always_comb begin
		creq.ref_name = (cand_q < CMD_W'(MAX_COMMANDS)) ? names_q[cand_q] : '0;
		creq.test_name = (n_q < CMD_W'(MAX_COMMANDS)) ? names_q[n_q] : '0;
		creq.pos = pos_q;
		creq.ch = ch_q;
		creq.mode = mode_q;
	end

	sclm_cmp u_cmp (.req(creq), .hit(hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_COMMANDS; i++) names_q[i] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_COUNT) count_q <= cfg_data[2:0];
			else names_q[cfg_index - 3'd1] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
			phase_q <= PH_WAIT;
			cr_q <= 1'b0; skip_q <= 1'b0; skipne_q <= 1'b0; locked_q <= 1'b0;
			scan_q <= 1'b0;
			cand_q <= '0; held_q <= '0; n_q <= '0; pos_q <= '0; len_q <= '0;
			ch_q <= '0; mode_q <= SCAN_CHAR; res_q <= '0;
		end else begin
			seq_q <= seq_d;
			phase_q <= phase_d;
			cr_q <= cr_d; skip_q <= skip_d; skipne_q <= skipne_d; locked_q <= locked_d;
			scan_q <= scan_d;
			cand_q <= cand_d; held_q <= held_d; n_q <= n_d; pos_q <= pos_d; len_q <= len_d;
			ch_q <= ch_d; mode_q <= mode_d; res_q <= res_d;
		end
	end

	always_comb begin
		logic [7:0] c;
		logic st;
		logic [7:0] sb;
		c = in_data.char_code;
		st = 1'b0;
		sb = c;
		seq_d = seq_q;
		phase_d = phase_q;
		cr_d = cr_q; skip_d = skip_q; skipne_d = skipne_q; locked_d = locked_q;
		scan_d = scan_q;
		cand_d = cand_q; held_d = held_q; n_d = n_q; pos_d = pos_q; len_d = len_q;
		ch_d = ch_q; mode_d = mode_q; res_d = res_q;
		unique case (seq_q)
			SEQ_IDLE: if (in_valid) begin
				seq_d = SEQ_SCAN;
				ch_d = c;
				res_d = '0;
				scan_d = 1'b0;
				mode_d = SCAN_CHAR;
				n_d = cand_q;
				if (in_data.req_type == REQ_RELEASE) begin
					locked_d = 1'b0;
				end else if (!locked_q) begin
					if (len_q < LEN_W'(MSG_SIZE)) len_d = len_q + 1'b1;
					unique case (phase_q)
						PH_WAIT: begin
							skip_d = 1'b0; cand_d = '0; len_d = LEN_W'(1); pos_d = '0;
							if (c == CH_CR) cr_d = 1'b1;
							else if (cr_q && c == CH_LF) begin
								phase_d = PH_MATCH; cr_d = 1'b0;
							end else cr_d = 1'b0;
						end
						PH_MATCH: if (!skip_q) begin
							if (is_alnum(c)) begin
								scan_d = 1'b1; mode_d = SCAN_CHAR;
							end else if (is_sep(c)) begin
								scan_d = 1'b1; mode_d = SCAN_SEP;
							end else begin
								skip_d = 1'b1; skipne_d = 1'b0;
								if (c == CH_CR) cr_d = 1'b1;
							end
						end else begin
							skipne_d = 1'b1;
							if (is_sep(c)) begin
								skip_d = 1'b0; cand_d = '0; pos_d = '0;
							end else if (c == CH_CR) cr_d = 1'b1;
							else if (cr_q && c == CH_LF) begin
								cr_d = 1'b0;
								if (len_q > LEN_W'(2)) begin
									scan_d = 1'b1; mode_d = SCAN_END;
									n_d = skipne_q ? cnt : cand_q;
								end else begin
									cand_d = '0; pos_d = '0; skip_d = 1'b0;
								end
							end else cr_d = 1'b0;
						end
						PH_PARAM: begin
							if (is_sep(c)) begin
								st = 1'b1; sb = CH_NUL;
							end else if (c == CH_CR) begin
								st = 1'b1; cr_d = 1'b1;
							end else if (cr_q && c == CH_LF) begin
								cr_d = 1'b0;
								res_d.param_write = 1'b1;
								res_d.param_pos = (pos_q == '0) ? '0 : pos_q - 1'b1;
								res_d.param_byte = CH_NUL;
								locked_d = 1'b1; held_d = cand_q; cand_d = '0;
								pos_d = '0; skip_d = 1'b0; phase_d = PH_WAIT;
							end else begin
								st = 1'b1; cr_d = 1'b0;
							end
							if (st) begin
								if (pos_q < POS_W'(MSG_SIZE - 1)) begin
									res_d.param_write = 1'b1; res_d.param_pos = pos_q;
									res_d.param_byte = sb;
									pos_d = pos_q + 1'b1;
								end else res_d.overflow = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			SEQ_SCAN: begin
				if (!scan_q || n_q >= cnt) begin
					seq_d = SEQ_OUT;
					if (scan_q) begin
						unique case (mode_q)
							SCAN_CHAR: begin
								skip_d = 1'b1; skipne_d = 1'b0; cand_d = '0; pos_d = '0;
							end
							SCAN_SEP: begin cand_d = '0; pos_d = '0; end
							default: begin
								res_d.line_dropped = 1'b1; phase_d = PH_WAIT;
								cand_d = '0; pos_d = '0; skip_d = 1'b0;
							end
						endcase
					end
				end else if (hit) begin
					seq_d = SEQ_OUT;
					unique case (mode_q)
						SCAN_CHAR: begin cand_d = n_q; pos_d = pos_q + 1'b1; end
						SCAN_SEP: begin cand_d = n_q; phase_d = PH_PARAM; pos_d = '0; end
						default: begin
							locked_d = 1'b1; held_d = n_q; phase_d = PH_WAIT;
							cand_d = '0; pos_d = '0; skip_d = 1'b0;
						end
					endcase
				end else begin
					n_d = n_q + 1'b1;
				end
				if (seq_d == SEQ_OUT) begin
					res_d.ready_res = locked_d;
					res_d.command_index = locked_d ? held_d : '0;
				end
			end
			SEQ_OUT: if (!out_stall) seq_d = SEQ_IDLE;
			default: seq_d = SEQ_IDLE;
		endcase
	end

	a_out_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(seq_q) == SEQ_SCAN)
		else $error("result without scan");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ready_res |-> out_data.command_index == '0)
		else $error("index without ready");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_SCAN |-> n_q <= 3'(MAX_COMMANDS)) else $error("scan index overrun");

endmodule
